[rtl/psf_pkg.sv]
// Shared types and constants for the poly-A segment finder.
// Used by psf_cfg, psf_scan, poly_a_segment_finder_core and the testbench. No dependencies.
package psf_pkg;

    localparam int POS_BITS_DEF    = 16;
    localparam int WEIGHT_BITS_DEF = 8;
    localparam int MAX_MIN_LEN_DEF = 64;

    localparam int BASE_W      = 3;
    localparam int SEG_W       = 16;
    localparam int MTM_W       = 16;
    localparam int MINLEN_W    = 7;
    localparam int WREG_W      = 64;
    localparam int CFG_IDX_W   = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_TERM_MODS  = 8'd0,
        REG_MIN_TAIL_LEN   = 8'd1,
        REG_TAIL_WEIGHTS   = 8'd2,
        REG_PREFIX_WEIGHTS = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MTM_W-1:0]    max_term_mods;
        logic [MINLEN_W-1:0] min_tail_len;
        logic [WREG_W-1:0]   tail_weights;
        logic [WREG_W-1:0]   prefix_weights;
    } t_cfg;

    // packed with found in the lowest bit
    typedef struct packed {
        logic             overflow;
        logic [SEG_W-1:0] seg_end;
        logic [SEG_W-1:0] seg_start;
        logic             found;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

[rtl/psf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies. Read during a write to the same address returns the old data.
module psf_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/psf_cfg.sv]
// Configuration register file of the poly-A segment finder.
// Depends on psf_pkg (t_cfg, register index codes).
module psf_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [psf_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [psf_pkg::WREG_W-1:0]    i_data,
    output psf_pkg::t_cfg             o_cfg
);

    import psf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_index)
                REG_MAX_TERM_MODS:  n_cfg.max_term_mods  = i_data[MTM_W-1:0];
                REG_MIN_TAIL_LEN:   n_cfg.min_tail_len   = i_data[MINLEN_W-1:0];
                REG_TAIL_WEIGHTS:   n_cfg.tail_weights   = i_data;
                REG_PREFIX_WEIGHTS: n_cfg.prefix_weights = i_data;
                default:            n_cfg = r_cfg;  // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_term_mods  <= '0;
            r_cfg.min_tail_len   <= MINLEN_W'(1);
            r_cfg.tail_weights   <= '0;
            r_cfg.prefix_weights <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/psf_scan.sv]
// Per-base scoring stage: running sums, best start offset and best segment.
// Depends on psf_pkg (t_cfg, t_result). Delay line lives in the top level.
module psf_scan #(
    parameter int POS_BITS    = psf_pkg::POS_BITS_DEF,
    parameter int WEIGHT_BITS = psf_pkg::WEIGHT_BITS_DEF,
    parameter int MAX_MIN_LEN = psf_pkg::MAX_MIN_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  psf_pkg::t_cfg                         i_cfg,
    input  logic [$clog2(MAX_MIN_LEN+1)-1:0]      i_len,
    input  logic                                  i_go,
    input  logic [psf_pkg::BASE_W-1:0]            i_base,
    input  logic                                  i_last,
    input  logic [POS_BITS:0]                     i_pos,
    input  logic [WEIGHT_BITS+POS_BITS+1:0]       i_dly_off,
    output logic                                  o_wr_en,
    output logic [WEIGHT_BITS+POS_BITS+1:0]       o_wr_off,
    output psf_pkg::t_result                      o_result
);

    import psf_pkg::*;

    localparam int SUM_W = WEIGHT_BITS + POS_BITS + 1;
    localparam int OFF_W = SUM_W + 1;
    localparam int PW    = POS_BITS + 1;
    localparam int LEN_W = $clog2(MAX_MIN_LEN + 1);
    localparam int PADW  = WREG_W + 8 * WEIGHT_BITS;
    localparam logic [PW-1:0] POS_LIMIT = {1'b0, {POS_BITS{1'b1}}};

    logic signed [SUM_W-1:0]  r_prefix, n_prefix;
    logic signed [SUM_W-1:0]  r_tail, n_tail;
    logic                     r_off_valid, n_off_valid;
    logic signed [OFF_W-1:0]  r_best_off, n_best_off;
    logic [POS_BITS-1:0]      r_best_off_start, n_best_off_start;
    logic                     r_score_valid, n_score_valid;
    logic signed [OFF_W-1:0]  r_top_score, n_top_score;
    logic [POS_BITS-1:0]      r_span_start, n_span_start;
    logic [POS_BITS-1:0]      r_span_end, n_span_end;

    logic [PADW-1:0]          w_tpad, w_ppad;
    logic [WEIGHT_BITS-1:0]   w_tlane, w_plane;
    logic [SUM_W-1:0]         w_tw, w_pw;
    logic                     w_act;
    logic signed [OFF_W-1:0]  w_off_cur;
    logic [PW-1:0]            w_jp1;
    logic                     w_start_ok;
    logic [POS_BITS-1:0]      w_i;
    logic signed [OFF_W-1:0]  w_o;
    logic                     w_take_off;
    logic signed [OFF_W-1:0]  w_score;
    logic                     w_take_score;
    logic                     w_ovf;
    logic                     w_found;

    // lanes past bit 63 read as zero through the padding
    assign w_tpad  = {{(8 * WEIGHT_BITS){1'b0}}, i_cfg.tail_weights};
    assign w_ppad  = {{(8 * WEIGHT_BITS){1'b0}}, i_cfg.prefix_weights};
    assign w_tlane = w_tpad[i_base * WEIGHT_BITS +: WEIGHT_BITS];
    assign w_plane = w_ppad[i_base * WEIGHT_BITS +: WEIGHT_BITS];
    assign w_tw    = {{(SUM_W - WEIGHT_BITS){w_tlane[WEIGHT_BITS-1]}}, w_tlane};
    assign w_pw    = {{(SUM_W - WEIGHT_BITS){w_plane[WEIGHT_BITS-1]}}, w_plane};

    assign w_act     = (i_pos < POS_LIMIT);
    assign w_off_cur = {r_prefix[SUM_W-1], r_prefix} - {r_tail[SUM_W-1], r_tail};
    assign w_jp1     = i_pos + PW'(1);
    assign w_start_ok = (32'(w_jp1) >= 32'(i_len)) &&
                        ((32'(w_jp1) - 32'(i_len)) < 32'(i_cfg.max_term_mods));
    assign w_i       = POS_BITS'(w_jp1 - PW'(i_len));
    // shortest length of one: the start is this base, not yet in the delay line
    assign w_o       = (i_len == LEN_W'(1)) ? w_off_cur : i_dly_off;
    assign w_take_off = w_start_ok && (!r_off_valid || (w_o > r_best_off));

    always_comb begin
        n_prefix         = r_prefix;
        n_tail           = r_tail;
        n_off_valid      = r_off_valid;
        n_best_off       = r_best_off;
        n_best_off_start = r_best_off_start;
        if (w_act) begin
            n_prefix = r_prefix + w_pw;
            n_tail   = r_tail + w_tw;
            if (w_take_off) begin
                n_off_valid      = 1'b1;
                n_best_off       = w_o;
                n_best_off_start = w_i;
            end
        end
    end

    assign w_score = n_best_off + {n_tail[SUM_W-1], n_tail};
    assign w_take_score = w_act && n_off_valid &&
                          (!r_score_valid || (w_score > r_top_score) ||
                           ((w_score == r_top_score) && (n_best_off_start < r_span_start)));

    always_comb begin
        n_score_valid = r_score_valid;
        n_top_score   = r_top_score;
        n_span_start  = r_span_start;
        n_span_end    = r_span_end;
        if (w_take_score) begin
            n_score_valid = 1'b1;
            n_top_score   = w_score;
            n_span_start  = n_best_off_start;
            n_span_end    = POS_BITS'(w_jp1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix      <= '0;
            r_tail        <= '0;
            r_off_valid   <= 1'b0;
            r_score_valid <= 1'b0;
        end else if (i_go) begin
            if (i_last) begin
                r_prefix      <= '0;
                r_tail        <= '0;
                r_off_valid   <= 1'b0;
                r_score_valid <= 1'b0;
            end else begin
                r_prefix      <= n_prefix;
                r_tail        <= n_tail;
                r_off_valid   <= n_off_valid;
                r_score_valid <= n_score_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_best_off       <= n_best_off;
            r_best_off_start <= n_best_off_start;
            r_top_score      <= n_top_score;
            r_span_start     <= n_span_start;
            r_span_end       <= n_span_end;
        end
    end

    // after the base, the count is past the limit iff it was at or past it before
    assign w_ovf   = (i_pos >= POS_LIMIT);
    assign w_found = !w_ovf && n_score_valid && (n_top_score > OFF_W'(0));

    assign o_wr_en             = i_go && w_act;
    assign o_wr_off            = w_off_cur;
    assign o_result.overflow   = w_ovf;
    assign o_result.found      = w_found;
    assign o_result.seg_start  = w_found ? SEG_W'(n_span_start) : '0;
    assign o_result.seg_end    = w_found ? SEG_W'(n_span_end) : '0;

`ifndef SYNTH
    a_score_needs_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_score_valid |-> r_off_valid)
        else $error("segment held without a start offset");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_score_valid |-> (r_span_end > r_span_start))
        else $error("held segment end not past its start");

    a_found_not_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_last) |-> !(o_result.found && o_result.overflow))
        else $error("result marked both found and overflow");
`endif

endmodule

[rtl/poly_a_segment_finder_core.sv]
// Poly-A segment finder: takes one base per beat and returns one result beat per read.
// A base enters the input register on acceptance and is scored from there; the delay
// line of start offsets is one psf_ram with its read issued at acceptance. A new base
// is accepted every cycle unless the input register holds a read's last base while
// a finished result is not taken; the result is registered when the last base is
// scored. Segment starts are limited by max_terminal_mods, lengths by min_tail_length
// (zero counts as one, saturated at MAX_MIN_LEN). Reads longer than 2^POS_BITS-1 bases
// report overflow. The user must write configuration only while no read is open;
// the block does not enforce it. Depends on psf_pkg, psf_cfg, psf_ram, psf_scan.
module poly_a_segment_finder_core #(
    parameter int POS_BITS    = psf_pkg::POS_BITS_DEF,
    parameter int WEIGHT_BITS = psf_pkg::WEIGHT_BITS_DEF,
    parameter int MAX_MIN_LEN = psf_pkg::MAX_MIN_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psf_pkg::WREG_W-1:0]          i_cfg_data,
    // base stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [psf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [2:0] base, [7:3] zero
    input  logic                                s_axis_tlast,  // last base of the read
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] found, [16:1] seg_start, [32:17] seg_end, [33] overflow, [39:34] zero
    output logic [psf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    import psf_pkg::*;

    localparam int SUM_W = WEIGHT_BITS + POS_BITS + 1;
    localparam int OFF_W = SUM_W + 1;
    localparam int PW    = POS_BITS + 1;
    localparam int LEN_W = $clog2(MAX_MIN_LEN + 1);
    localparam int AW    = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;
    localparam int RAW_W = $clog2(2 * MAX_MIN_LEN + 1);
    localparam logic [PW-1:0] POS_LIMIT = {1'b0, {POS_BITS{1'b1}}};

    t_cfg               w_cfg;
    logic [LEN_W-1:0]   w_len;
    logic               w_go;
    logic               w_acc;
    logic [RAW_W-1:0]   w_ra_sum;
    logic [AW-1:0]      w_ra;
    logic               w_wr_en;
    logic [OFF_W-1:0]   w_wr_off;
    logic [OFF_W-1:0]   w_ram_q;
    logic [OFF_W-1:0]   w_dly_off;
    t_result            w_result;

    logic [PW-1:0]      r_fpos, n_fpos;
    logic [AW-1:0]      r_fwp, n_fwp;
    logic               r_s1_valid;
    logic [BASE_W-1:0]  r_s1_base;
    logic               r_s1_last;
    logic [PW-1:0]      r_s1_pos;
    logic [AW-1:0]      r_s1_wp;
    logic               r_byp_hit;
    logic [OFF_W-1:0]   r_byp_off;
    logic               r_out_valid;
    t_result            r_out;

    assign o_cfg_ready = 1'b1;

    psf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        if (w_cfg.min_tail_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(w_cfg.min_tail_len) > 32'(MAX_MIN_LEN)) begin
            w_len = LEN_W'(MAX_MIN_LEN);
        end else begin
            w_len = LEN_W'(w_cfg.min_tail_len);
        end
    end

    // stage advances unless it holds a last base and the result register is blocked
    assign w_go  = r_s1_valid && !(r_s1_last && r_out_valid && !m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_go;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // start slot for this base: (pos + 1 - len) mod depth, pos taken mod depth
    assign w_ra_sum = RAW_W'(r_fwp) + RAW_W'(MAX_MIN_LEN + 1) - RAW_W'(w_len);
    assign w_ra     = (w_ra_sum >= RAW_W'(MAX_MIN_LEN)) ?
                      AW'(w_ra_sum - RAW_W'(MAX_MIN_LEN)) : AW'(w_ra_sum);

    always_comb begin
        n_fpos = r_fpos;
        n_fwp  = r_fwp;
        if (w_acc) begin
            if (s_axis_tlast) begin
                n_fpos = '0;
                n_fwp  = '0;
            end else begin
                if (r_fpos <= POS_LIMIT) begin
                    n_fpos = r_fpos + PW'(1);
                end
                n_fwp = (r_fwp == AW'(MAX_MIN_LEN - 1)) ? '0 : r_fwp + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpos      <= '0;
            r_fwp       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fpos <= n_fpos;
            r_fwp  <= n_fwp;
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_base <= s_axis_tdata[BASE_W-1:0];
            r_s1_last <= s_axis_tlast;
            r_s1_pos  <= r_fpos;
            r_s1_wp   <= r_fwp;
            // the stage ahead writes this cycle; RAM would return the old entry
            r_byp_hit <= w_wr_en && (r_s1_wp == w_ra);
            r_byp_off <= w_wr_off;
        end
        if (w_go && r_s1_last) begin
            r_out <= w_result;
        end
    end

    psf_ram #(
        .WIDTH (OFF_W),
        .DEPTH (MAX_MIN_LEN)
    ) u_dly (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_wp),
        .i_wr_data (w_wr_off),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_ra),
        .o_rd_data (w_ram_q)
    );

    assign w_dly_off = r_byp_hit ? r_byp_off : w_ram_q;

    psf_scan #(
        .POS_BITS    (POS_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .MAX_MIN_LEN (MAX_MIN_LEN)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_len     (w_len),
        .i_go      (w_go),
        .i_base    (r_s1_base),
        .i_last    (r_s1_last),
        .i_pos     (r_s1_pos),
        .i_dly_off (w_dly_off),
        .o_wr_en   (w_wr_en),
        .o_wr_off  (w_wr_off),
        .o_result  (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out};

`ifndef SYNTH
    a_hold_on_blocked_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("base accepted while finished read is blocked");

    a_count_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && s_axis_tlast) |=> (r_fpos == '0))
        else $error("base count not cleared after last beat");

    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_pos == '0)) |-> (r_s1_wp == '0))
        else $error("delay slot out of step with base count");
`endif

endmodule

[tb/tb_poly_a_segment_finder_core.sv]
// Self-checking testbench for poly_a_segment_finder_core: random reads with shaped poly-A
// content, a built-in scoring predictor and a beat-by-beat check of every read report.
// Depends on psf_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_poly_a_segment_finder_core;
    import psf_pkg::*;

    localparam int          CLK_HALF      = 2;
    localparam int          RST_CYCLES    = 9;
    localparam int          GAP_PCT       = 35;
    localparam int          PHASE_BASES   = 205;
    localparam int          NUM_PHASES    = 9;
    localparam int unsigned POS_MAX       = (1 << POS_BITS_DEF) - 1;
    localparam int          DELAY_DEPTH   = MAX_MIN_LEN_DEF;
    localparam longint      CYCLE_LIMIT   = 1_500_000;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE = 8'hA5;

    localparam logic [2:0]  BASE_A        = 3'd0;

    typedef struct {
        logic [2:0] code;
        logic       last;
    } t_read_base;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [WREG_W-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [2:0] base, [7:3] zero
    logic                   s_axis_tlast = 1'b0; // last base of the read
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] found, [16:1] seg_start, [32:17] seg_end, [33] overflow, [39:34] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    poly_a_segment_finder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // register shadow, reset values
    logic [MTM_W-1:0]    cfg_term_mods = '0;
    logic [MINLEN_W-1:0] cfg_min_len = 7'd1;
    logic [WREG_W-1:0]   cfg_tail_w = '0;
    logic [WREG_W-1:0]   cfg_prefix_w = '0;

    // scoring state of the open read
    int unsigned rd_pos = 0;
    longint      prefix_acc = 0;
    longint      tail_acc = 0;
    longint      offset_line [DELAY_DEPTH];
    bit          offset_ok = 0;
    longint      best_offset = 0;
    int unsigned best_offset_start = 0;
    bit          span_ok = 0;
    longint      top_score = -1;
    int unsigned span_start = 0;
    int unsigned span_end = 0;

    t_read_base  bases_to_send [$];
    t_result     reports_due [$];

    bit          gaps_on = 1'b1;
    int          n_pushed = 0;
    int          n_accepted = 0;
    int          n_reports = 0;
    int          n_found = 0;
    int          n_overflow = 0;
    int          n_writes = 0;
    int          errors = 0;
    longint      cycles = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic longint lane_weight(input logic [WREG_W-1:0] w, input logic [2:0] code);
        logic signed [7:0] lane;
        lane = w[code*8 +: 8];
        return longint'(lane);
    endfunction

    // Streaming max-score search: each start's offset waits in the delay line until
    // its shortest segment has closed, then joins the running maximum.
    task automatic score_base(input logic [2:0] code, input logic last);
        int unsigned j, len, i;
        longint      o, s;
        t_result     r;
        if (rd_pos > POS_MAX) begin
            // overflowed read, base dropped
        end else if (rd_pos == POS_MAX) begin
            rd_pos = POS_MAX + 1;
        end else begin
            j   = rd_pos;
            len = 32'(cfg_min_len);
            if (len < 1) len = 1;
            if (len > DELAY_DEPTH) len = DELAY_DEPTH;
            offset_line[j % DELAY_DEPTH] = prefix_acc - tail_acc;
            tail_acc   += lane_weight(cfg_tail_w, code);
            prefix_acc += lane_weight(cfg_prefix_w, code);
            if (j + 1 >= len) begin
                i = j + 1 - len;
                if (i < cfg_term_mods) begin
                    o = offset_line[i % DELAY_DEPTH];
                    if (!offset_ok || o > best_offset) begin
                        offset_ok         = 1;
                        best_offset       = o;
                        best_offset_start = i;
                    end
                end
            end
            if (offset_ok) begin
                s = best_offset + tail_acc;
                if (!span_ok || s > top_score ||
                    (s == top_score && best_offset_start < span_start)) begin
                    span_ok    = 1;
                    top_score  = s;
                    span_start = best_offset_start;
                    span_end   = j + 1;
                end
            end
            rd_pos = j + 1;
        end
        if (last) begin
            r = '0;
            if (rd_pos > POS_MAX) begin
                r.overflow = 1'b1;
                n_overflow++;
            end else if (span_ok && top_score >= 1) begin
                r.found     = 1'b1;
                r.seg_start = span_start[SEG_W-1:0];
                r.seg_end   = span_end[SEG_W-1:0];
                n_found++;
            end
            reports_due.push_back(r);
            rd_pos      = 0;
            prefix_acc  = 0;
            tail_acc    = 0;
            offset_ok   = 0;
            best_offset = 0;
            best_offset_start = 0;
            span_ok     = 0;
            top_score   = -1;
            span_start  = 0;
            span_end    = 0;
        end
    endtask

    // base driver
    always @(posedge i_clk) begin
        t_read_base nb;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                score_base(s_axis_tdata[2:0], s_axis_tlast);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bases_to_send.size() != 0 &&
                    !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
                    nb = bases_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_TDATA_W-3){1'b0}}, nb.code};
                    s_axis_tlast  <= nb.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        t_result act, exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                act = m_axis_tdata[RESULT_W-1:0];
                n_reports++;
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected report beat %h", $time, act);
                    errors++;
                end else begin
                    exp_r = reports_due.pop_front();
                    if (act.found !== exp_r.found || act.seg_start !== exp_r.seg_start ||
                        act.seg_end !== exp_r.seg_end || act.overflow !== exp_r.overflow) begin
                        $display("%0t: report mismatch exp found=%0d start=%0d end=%0d ovf=%0d",
                                 $time, exp_r.found, exp_r.seg_start, exp_r.seg_end,
                                 exp_r.overflow);
                        $display("%0t:                 got found=%0d start=%0d end=%0d ovf=%0d",
                                 $time, act.found, act.seg_start, act.seg_end, act.overflow);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d bases accepted, %0d reports pending",
                     $time, n_accepted, n_pushed, reports_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WREG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        n_writes++;
        case (idx)
            REG_MAX_TERM_MODS:  cfg_term_mods = data[MTM_W-1:0];
            REG_MIN_TAIL_LEN:   cfg_min_len   = data[MINLEN_W-1:0];
            REG_TAIL_WEIGHTS:   cfg_tail_w    = data;
            REG_PREFIX_WEIGHTS: cfg_prefix_w  = data;
            default: ;
        endcase
    endtask

    task automatic push_base(input logic [2:0] code, input logic last);
        t_read_base b;
        b.code = code;
        b.last = last;
        bases_to_send.push_back(b);
        n_pushed++;
    endtask

    // wait for the block to go idle: all bases in, all reports out, pipeline flushed
    task automatic drain();
        while (n_accepted != n_pushed || bases_to_send.size() != 0 || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly a non-A lead-in, a noisy A run and some trailing junk; the rest pure noise
    task automatic push_read(input int span);
        logic [2:0] codes [$];
        int         lead, run, trail, k;
        if ($urandom_range(99) < 80) begin
            lead  = $urandom_range(0, 8);
            run   = $urandom_range(1, span);
            trail = $urandom_range(0, 6);
            for (k = 0; k < lead; k++) codes.push_back(3'($urandom_range(1, 7)));
            for (k = 0; k < run; k++)
                codes.push_back(($urandom_range(99) < 8) ? 3'($urandom_range(1, 7)) : BASE_A);
            for (k = 0; k < trail; k++) codes.push_back(3'($urandom_range(0, 7)));
        end else begin
            run = $urandom_range(1, span);
            for (k = 0; k < run; k++) codes.push_back(3'($urandom_range(0, 7)));
        end
        for (k = 0; k < codes.size(); k++) push_base(codes[k], k == codes.size() - 1);
    endtask

    // A lanes favored in the tail weights, the other codes in the prefix weights
    function automatic logic [WREG_W-1:0] pick_weights(input bit for_tail);
        logic [WREG_W-1:0] w;
        int                c;
        if ($urandom_range(99) < 20) return {$urandom, $urandom};
        for (c = 0; c < 8; c++) begin
            if (for_tail == (c == 0)) w[c*8 +: 8] = 8'($urandom_range(0, 127));
            else                      w[c*8 +: 8] = 8'(-$urandom_range(0, 128));
        end
        return w;
    endfunction

    initial begin
        int ph, mark, k;
        logic [WREG_W-1:0] d;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: no start allowed, never found
        push_base(3'd7, 1'b1);
        drain();

        write_reg(REG_MAX_TERM_MODS, 64'd2);
        write_reg(REG_MIN_TAIL_LEN, 64'd0);        // zero counts as one
        write_reg(REG_TAIL_WEIGHTS, 64'h007f_8001_00ff_807f);
        write_reg(REG_PREFIX_WEIGHTS, 64'h7f80_00ff_0305_7f80);
        push_base(BASE_A, 1'b1);
        for (k = 1; k <= 8; k++) push_base(3'(k), k == 8);
        push_base(3'd1, 1'b0);
        push_base(BASE_A, 1'b0);
        push_base(BASE_A, 1'b0);
        push_base(BASE_A, 1'b1);
        push_base(3'd4, 1'b0);
        push_base(3'd4, 1'b0);
        push_base(3'd6, 1'b0);
        push_base(BASE_A, 1'b1);
        drain();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            gaps_on = (ph != 4);
            d = {$urandom, $urandom};
            case (ph % 5)
                0: d[MTM_W-1:0] = 16'hFFFF;
                1: d[MTM_W-1:0] = 16'($urandom_range(1, 4));
                2: d[MTM_W-1:0] = 16'($urandom_range(5, 40));
                3: d[MTM_W-1:0] = (ph == 3) ? 16'd0 : 16'($urandom_range(0, 300));
                default: d[MTM_W-1:0] = 16'($urandom);
            endcase
            write_reg(REG_MAX_TERM_MODS, d);
            d = {$urandom, $urandom};
            case (ph % 4)
                0: d[MINLEN_W-1:0] = (ph == 0) ? 7'd0 : 7'd1;
                1: d[MINLEN_W-1:0] = (ph == 1) ? 7'd64 : 7'($urandom_range(13, 64));
                2: d[MINLEN_W-1:0] = 7'($urandom_range(1, 12));
                default: d[MINLEN_W-1:0] = (ph == 3) ? 7'd127 : 7'($urandom_range(65, 127));
            endcase
            write_reg(REG_MIN_TAIL_LEN, d);
            write_reg(REG_TAIL_WEIGHTS, pick_weights(1'b1));
            write_reg(REG_PREFIX_WEIGHTS, pick_weights(1'b0));
            if (ph == 2) write_reg(REG_IDX_SPARE, {$urandom, $urandom});
            mark = n_pushed;
            while (n_pushed - mark < PHASE_BASES)
                push_read(($urandom_range(99) < 15) ? 140 : 40);
            drain();

            // longest legal read, then a read two bases past the limit, then a short one after it
            if (ph == 5) begin
                write_reg(REG_MAX_TERM_MODS, 64'hFFFF);
                write_reg(REG_MIN_TAIL_LEN, 64'($urandom_range(1, 64)));
                for (k = 0; k < POS_MAX; k++)
                    push_base(($urandom_range(99) < 60) ? BASE_A : 3'($urandom_range(0, 7)),
                              k == POS_MAX - 1);
                for (k = 0; k < POS_MAX + 2; k++)
                    push_base(3'($urandom_range(0, 7)), k == POS_MAX + 1);
                push_read(20);
                drain();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, reports_due.size());
            errors++;
        end
        $display("Run covered %0d bases and %0d read reports over %0d register writes",
                 n_accepted, n_reports, n_writes);
        $display("Reports with a segment: %0d, overflowed reads: %0d, mismatches: %0d",
                 n_found, n_overflow, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/psf_pkg.sv
rtl/psf_ram.sv
rtl/psf_cfg.sv
rtl/psf_scan.sv
rtl/poly_a_segment_finder_core.sv
tb/tb_poly_a_segment_finder_core.sv
